[hw/rtl/pds_pkg.sv]
// pds_pkg: field widths, walk constants, controller state type and the
// command/status structs shared by the divider search controller and datapath.
// No dependencies.
package pds_pkg;

  localparam int unsigned T_W   = 30;  // target_hz width, also holds the scaled target
  localparam int unsigned STG_W = 2;   // prescale_stages width
  localparam int unsigned FB_W  = 8;   // feedback_mult width
  localparam int unsigned PD_W  = 10;  // post_div width
  localparam int unsigned NUM_W = 32;  // 5 MHz times any multiplier up to 512
  localparam int unsigned SF_W  = 10;  // prescale factor width

  localparam logic [T_W-1:0]   SCALE_LIMIT  = 30'd800000;
  localparam logic [SF_W-1:0]  SCALE_FACTOR = 10'd500;
  localparam logic [NUM_W-1:0] REF_HZ       = 32'd5000000;
  localparam logic [STG_W-1:0] SCALE_LAST   = 2'd2;  // three prescale checks: 0, 1, 2

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCALE,
    ST_DIFF,
    ST_MUL,
    ST_UPD,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic load;   // take a new target
    logic scale;  // one prescale check
    logic diff;   // register |candidate - target| and the step direction
    logic mul;    // register both error cross-products
    logic upd;    // keep a better pair, step m or c
  } dp_cmd_t;

  typedef struct packed {
    logic walk_done;  // m past its max or c past its max
  } dp_status_t;

endpackage

[hw/rtl/pds_dp.sv]
// pds_dp: datapath of the divider search: prescale, incremental candidate and
// target products, error cross-product compare and best-pair registers.
// Depends on pds_pkg.
module pds_dp import pds_pkg::*; #(
  parameter int unsigned MULT_MIN = 80,
  parameter int unsigned MULT_MAX = 250,
  parameter int unsigned DIV_MAX  = 512
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  dp_cmd_t          cmd_i,
  output dp_status_t       status_o,
  input  logic [T_W-1:0]   target_hz_i,
  output logic [STG_W-1:0] prescale_stages_o,
  output logic [FB_W-1:0]  feedback_mult_o,
  output logic [PD_W-1:0]  post_div_o
);

  localparam int unsigned M_TOP  = (MULT_MIN > MULT_MAX + 1) ? MULT_MIN : MULT_MAX + 1;
  localparam int unsigned M_W    = $clog2(M_TOP + 1);
  localparam int unsigned C_W    = $clog2(DIV_MAX + 2);
  localparam int unsigned TC_W   = T_W + C_W;
  localparam int unsigned PROD_W = TC_W + C_W;

  localparam logic [M_W-1:0] M_MIN = M_W'(MULT_MIN);
  localparam logic [M_W-1:0] M_MAX = M_W'(MULT_MAX);
  localparam logic [C_W-1:0] C_MAX = C_W'(DIV_MAX);
  localparam logic [C_W-1:0] C_ONE = C_W'(1);
  localparam logic [63:0]    NUM_INIT64 = 64'(REF_HZ) * 64'(MULT_MIN);
  localparam logic [NUM_W-1:0] NUM_INIT = NUM_INIT64[NUM_W-1:0];

  logic [T_W-1:0]    t_q;
  logic [STG_W-1:0]  stages_q;
  logic [M_W-1:0]    m_q;
  logic [C_W-1:0]    c_q;
  logic [NUM_W-1:0]  num_q;      // REF_HZ * m
  logic [TC_W-1:0]   tc_q;       // t * c
  logic [TC_W-1:0]   err_q;
  logic              lt_q;
  logic [PROD_W-1:0] prod_new_q;
  logic [PROD_W-1:0] prod_best_q;
  logic [M_W-1:0]    best_m_q;
  logic [C_W-1:0]    best_c_q;
  logic [TC_W-1:0]   best_err_q;
  logic              have_q;

  logic [T_W+SF_W-1:0] t_scaled;
  logic [TC_W-1:0]     num_ext;
  logic                lt_d;
  logic [TC_W-1:0]     err_d;
  logic                better;
  logic [FB_W+M_W-1:0] m_ext;
  logic [PD_W+C_W-1:0] c_ext;

  assign t_scaled = T_W'(t_q) * SCALE_FACTOR;
  assign num_ext  = TC_W'(num_q);
  assign lt_d     = num_ext < tc_q;
  assign err_d    = lt_d ? (tc_q - num_ext) : (num_ext - tc_q);
  // strictly smaller error keeps the first pair among equals
  assign better   = !have_q || (prod_new_q < prod_best_q);

  assign status_o.walk_done = (m_q > M_MAX) || (c_q > C_MAX);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_q <= 1'b0;
    end else if (cmd_i.load) begin
      have_q <= 1'b0;
    end else if (cmd_i.upd) begin
      have_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      t_q      <= target_hz_i;
      tc_q     <= TC_W'(target_hz_i);
      stages_q <= '0;
      m_q      <= M_MIN;
      c_q      <= C_ONE;
      num_q    <= NUM_INIT;
      best_m_q <= M_MIN;
      best_c_q <= C_ONE;
    end
    if (cmd_i.scale && (t_q < SCALE_LIMIT)) begin
      // scaled value stays below 4e8 here, so the cut is lossless
      t_q      <= t_scaled[T_W-1:0];
      tc_q     <= TC_W'(t_scaled[T_W-1:0]);
      stages_q <= stages_q + STG_W'(1);
    end
    if (cmd_i.diff) begin
      err_q <= err_d;
      lt_q  <= lt_d;
    end
    if (cmd_i.mul) begin
      prod_new_q  <= PROD_W'(err_q) * PROD_W'(best_c_q);
      prod_best_q <= PROD_W'(best_err_q) * PROD_W'(c_q);
    end
    if (cmd_i.upd) begin
      if (better) begin
        best_err_q <= err_q;
        best_m_q   <= m_q;
        best_c_q   <= c_q;
      end
      if (lt_q) begin
        m_q   <= m_q + M_W'(1);
        num_q <= num_q + REF_HZ;
      end else begin
        c_q  <= c_q + C_W'(1);
        tc_q <= tc_q + TC_W'(t_q);
      end
    end
  end

  assign m_ext = {{FB_W{1'b0}}, best_m_q};
  assign c_ext = {{PD_W{1'b0}}, best_c_q};

  assign prescale_stages_o = stages_q;
  assign feedback_mult_o   = m_ext[FB_W-1:0];
  assign post_div_o        = c_ext[PD_W-1:0];

`ifndef ASSERT_OFF
  a_best_c_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    have_q |-> (best_c_q >= C_ONE) && (best_c_q <= C_MAX))
    else $error("best divider out of range");

  a_step_m: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.upd && lt_q |=> (m_q == $past(m_q) + M_W'(1)) && (c_q == $past(c_q)))
    else $error("multiplier step wrong");

  a_step_c: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.upd && !lt_q |=> tc_q == $past(tc_q) + TC_W'($past(t_q)))
    else $error("target product not advanced with divider");
`endif

endmodule

[hw/rtl/pds_ctrl.sv]
// pds_ctrl: sequencer of the divider search: accepts a start, runs three
// prescale checks, then diff/multiply/update per walk step, then strobes done.
// Depends on pds_pkg.
module pds_ctrl import pds_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  output logic       busy_o,
  output logic       done_o,
  input  dp_status_t status_i,
  output dp_cmd_t    cmd_o
);

  state_e           state_q, state_d;
  logic [STG_W-1:0] cnt_q, cnt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) state_d = ST_SCALE;
      end
      ST_SCALE: begin
        if (cnt_q == SCALE_LAST) state_d = ST_DIFF;
      end
      ST_DIFF: begin
        state_d = status_i.walk_done ? ST_DONE : ST_MUL;
      end
      ST_MUL: begin
        state_d = ST_UPD;
      end
      ST_UPD: begin
        state_d = ST_DIFF;
      end
      ST_DONE: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // outputs
  always_comb begin
    cmd_o  = '0;
    cnt_d  = '0;
    busy_o = 1'b1;
    done_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        busy_o     = 1'b0;
        cmd_o.load = start_i;
      end
      ST_SCALE: begin
        cmd_o.scale = 1'b1;
        cnt_d       = (cnt_q == SCALE_LAST) ? '0 : cnt_q + STG_W'(1);
      end
      ST_DIFF: begin
        cmd_o.diff = !status_i.walk_done;
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
      end
      ST_UPD: begin
        cmd_o.upd = 1'b1;
      end
      ST_DONE: begin
        done_o = 1'b1;
      end
      default: begin
        busy_o = 1'b1;
      end
    endcase
  end

`ifndef ASSERT_OFF
  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o && !busy_o)
    else $error("done strobe longer than one cycle");

  a_start_scale: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> (state_q == ST_SCALE) && (cnt_q == '0))
    else $error("accepted start did not begin prescale");

  a_cnt_scale: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != '0 |-> state_q == ST_SCALE)
    else $error("prescale count live outside prescale");

  a_walk_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIFF) && status_i.walk_done |=> done_o)
    else $error("finished walk did not report");
`endif

endmodule

[hw/rtl/pll_divider_search.sv]
// pll_divider_search: accepts a target frequency and returns prescale count, M and C.
// The accepting edge loads the target; then come the prescale checks, one diff, multiply
// and update round per walk step (at most 682 steps with default parameters) and a done_o
// pulse; one item at a time, busy stays high through the result cycle.
// Each walk step uses the shared subtract, multiply and compare path in turn.
// Reset (async, active low) returns the controller to idle; results cannot be stalled.
module pll_divider_search import pds_pkg::*; #(
  parameter int unsigned MULT_MIN = 80,
  parameter int unsigned MULT_MAX = 250,
  parameter int unsigned DIV_MAX  = 512
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  logic [T_W-1:0]   target_hz_i,
  output logic             done_o,
  output logic [STG_W-1:0] prescale_stages_o,
  output logic [FB_W-1:0]  feedback_mult_o,
  output logic [PD_W-1:0]  post_div_o
);

  dp_cmd_t    cmd;
  dp_status_t status;

  pds_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .busy_o   (busy),
    .done_o   (done_o),
    .status_i (status),
    .cmd_o    (cmd)
  );

  pds_dp #(
    .MULT_MIN (MULT_MIN),
    .MULT_MAX (MULT_MAX),
    .DIV_MAX  (DIV_MAX)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .status_o          (status),
    .target_hz_i       (target_hz_i),
    .prescale_stages_o (prescale_stages_o),
    .feedback_mult_o   (feedback_mult_o),
    .post_div_o        (post_div_o)
  );

endmodule

[tb/sv/pds_checker.sv]
// pds_checker: watches the command and result ports of pll_divider_search,
// predicts prescale count, M and C per accepted target and compares each result.
// Depends on pds_pkg for the port widths.
module pds_checker import pds_pkg::*; #(
  parameter int unsigned MULT_MIN = 80,
  parameter int unsigned MULT_MAX = 250,
  parameter int unsigned DIV_MAX  = 512
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  input  logic             busy,
  input  logic [T_W-1:0]   target_hz_i,
  input  logic             done_o,
  input  logic [STG_W-1:0] prescale_stages_o,
  input  logic [FB_W-1:0]  feedback_mult_o,
  input  logic [PD_W-1:0]  post_div_o,
  output int               mismatch_count,
  output int               outstanding
);

  localparam longint unsigned PRESCALE_BELOW = 800000;
  localparam longint unsigned PRESCALE_RATIO = 500;
  localparam longint unsigned VCO_STEP_HZ    = 5000000;
  localparam int unsigned     PRESCALE_TRIES = 3;

  typedef struct packed {
    logic [STG_W-1:0] stages;
    logic [FB_W-1:0]  mult;
    logic [PD_W-1:0]  div;
  } pll_setting_t;

  pll_setting_t settings_q[$];
  int           fail_cnt = 0;
  int           pend_cnt = 0;

  assign mismatch_count = fail_cnt;
  assign outstanding    = pend_cnt;

  // walk m up while the candidate is below the target, c up otherwise;
  // keep the first pair whose error is strictly smallest (exact cross-products)
  function automatic pll_setting_t search_dividers(input logic [T_W-1:0] target);
    longint unsigned scaled, num, tc, err, best_err, m, c, best_m, best_c;
    int unsigned     stage_cnt, i;
    bit              found;
    pll_setting_t    res;
    scaled    = target;
    stage_cnt = 0;
    m         = MULT_MIN;
    c         = 1;
    best_m    = 1;
    best_c    = 1;
    best_err  = 0;
    found     = 1'b0;
    for (i = 0; i < PRESCALE_TRIES; i++) begin
      if (scaled < PRESCALE_BELOW) begin
        scaled    = scaled * PRESCALE_RATIO;
        stage_cnt = stage_cnt + 1;
      end
    end
    while (m <= MULT_MAX && c <= DIV_MAX) begin
      num = VCO_STEP_HZ * m;
      tc  = scaled * c;
      err = (num >= tc) ? num - tc : tc - num;
      if (!found || err * best_c < best_err * c) begin
        found    = 1'b1;
        best_err = err;
        best_m   = m;
        best_c   = c;
      end
      if (num < tc) m++;
      else c++;
    end
    if (best_c < 1) best_c = 1;
    if (best_c > DIV_MAX) best_c = DIV_MAX;
    if (best_m < MULT_MIN) best_m = MULT_MIN;
    if (best_m > MULT_MAX) best_m = MULT_MAX;
    res.stages = stage_cnt[STG_W-1:0];
    res.mult   = best_m[FB_W-1:0];
    res.div    = best_c[PD_W-1:0];
    return res;
  endfunction

  always @(posedge clk_i) begin
    pll_setting_t want;
    if (rst_ni) begin
      // result first, before any new beat is queued
      if (done_o) begin
        if (settings_q.size() == 0) begin
          $error("unexpected result beat: stages %0d, M %0d, C %0d",
                 prescale_stages_o, feedback_mult_o, post_div_o);
          fail_cnt = fail_cnt + 1;
        end else begin
          want = settings_q.pop_front();
          if (prescale_stages_o !== want.stages) begin
            $error("prescale_stages: expected %0d, actual %0d", want.stages, prescale_stages_o);
            fail_cnt = fail_cnt + 1;
          end
          if (feedback_mult_o !== want.mult) begin
            $error("feedback_mult: expected %0d, actual %0d", want.mult, feedback_mult_o);
            fail_cnt = fail_cnt + 1;
          end
          if (post_div_o !== want.div) begin
            $error("post_div: expected %0d, actual %0d", want.div, post_div_o);
            fail_cnt = fail_cnt + 1;
          end
        end
      end
      if (start && !busy) settings_q.push_back(search_dividers(target_hz_i));
      pend_cnt = settings_q.size();
    end
  end

endmodule

[tb/sv/tb_pll_divider_search.sv]
// tb_pll_divider_search: drives target frequencies into pll_divider_search with
// corner values, then random ones under several idle patterns; pds_checker scores.
// Depends on pds_pkg, pll_divider_search and pds_checker.
module tb_pll_divider_search import pds_pkg::*;;

  localparam int unsigned MULT_MIN   = 80;
  localparam int unsigned MULT_MAX   = 250;
  localparam int unsigned DIV_MAX    = 512;
  localparam int unsigned DRAIN_CYC  = 2100;  // longest walk plus margin
  localparam int unsigned RAND_BEATS = 150;   // per idle phase

  logic             clk_i       = 1'b0;
  logic             rst_ni      = 1'b0;
  logic             start       = 1'b0;
  logic [T_W-1:0]   target_hz_i = '0;
  logic             busy;
  logic             done_o;
  logic [STG_W-1:0] prescale_stages_o;
  logic [FB_W-1:0]  feedback_mult_o;
  logic [PD_W-1:0]  post_div_o;
  int               mismatch_count;
  int               outstanding;

  always #1 clk_i = ~clk_i;

  pll_divider_search #(
    .MULT_MIN (MULT_MIN),
    .MULT_MAX (MULT_MAX),
    .DIV_MAX  (DIV_MAX)
  ) DUT (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start             (start),
    .busy              (busy),
    .target_hz_i       (target_hz_i),
    .done_o            (done_o),
    .prescale_stages_o (prescale_stages_o),
    .feedback_mult_o   (feedback_mult_o),
    .post_div_o        (post_div_o)
  );

  pds_checker #(
    .MULT_MIN (MULT_MIN),
    .MULT_MAX (MULT_MAX),
    .DIV_MAX  (DIV_MAX)
  ) u_checker (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start             (start),
    .busy              (busy),
    .target_hz_i       (target_hz_i),
    .done_o            (done_o),
    .prescale_stages_o (prescale_stages_o),
    .feedback_mult_o   (feedback_mult_o),
    .post_div_o        (post_div_o),
    .mismatch_count    (mismatch_count),
    .outstanding       (outstanding)
  );

  // start stays high across back-to-back beats; a gap waits out the walk first
  task automatic issue_target(input logic [T_W-1:0] value, input int unsigned idle_pct);
    start       <= 1'b1;
    target_hz_i <= value;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    if ($urandom_range(99) < idle_pct) begin
      start       <= 1'b0;
      target_hz_i <= T_W'($urandom());
      @(posedge clk_i);
      while (busy) @(posedge clk_i);
      while ($urandom_range(99) < idle_pct) @(posedge clk_i);
    end
  endtask

  function automatic logic [T_W-1:0] random_target();
    longint unsigned near_hit;
    int unsigned     raw;
    raw = $urandom();
    case ($urandom_range(4))
      0, 1: random_target = raw[T_W-1:0];
      2: random_target = T_W'($urandom_range(3199));
      3: random_target = T_W'($urandom_range(1000000000, 1));
      default: begin
        // close to an exact 5 MHz * m / c candidate
        near_hit = (64'd5000000 * $urandom_range(MULT_MAX, MULT_MIN)) / $urandom_range(DIV_MAX, 1);
        near_hit = near_hit + $urandom_range(4) - 2;
        random_target = near_hit[T_W-1:0];
      end
    endcase
  endfunction

  initial begin
    int unsigned corner_targets[$];
    int unsigned idle_pct;
    corner_targets = '{0, 1, 2, 3, 4, 1599, 1600, 1601, 3199, 3200, 799999, 800000,
                       800001, 781250, 5000000, 10000000, 25000000, 123456789,
                       400000000, 1000000000, 1073741823, 715827882, 357913941};
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (corner_targets[i]) issue_target(corner_targets[i][T_W-1:0], 11);
    for (int phase = 0; phase < 3; phase++) begin
      idle_pct = (phase == 0) ? 0 : (phase == 1) ? 83 : 11;
      repeat (RAND_BEATS) issue_target(random_target(), idle_pct);
    end
    start <= 1'b0;
    while (outstanding != 0) @(posedge clk_i);
    repeat (DRAIN_CYC) @(posedge clk_i);
    // a beat still waiting for its result counts as a failure
    if (mismatch_count == 0 && outstanding == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #40000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
